[hw/rtl/i2d_pkg.sv]
// ----------------------------------------------------------------------------
// i2d_pkg: shared definitions for the integer to decimal text converter
// Widths, character codes and the status word of the conversion unit.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int STEP_W  = $clog2(VALUE_W);
  localparam int IDX_W   = $clog2(DIGITS);
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

endpackage

[hw/rtl/i2d_if.sv]
// ----------------------------------------------------------------------------
// i2d_if: handshake channels of the converter
// One channel carries the input number, the other the text characters.
// ----------------------------------------------------------------------------
interface i2d_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [i2d_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2d_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2d_pkg::CHAR_W-1:0]  character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[hw/rtl/i2d_bcd.sv]
// ----------------------------------------------------------------------------
// i2d_bcd: iterative binary to BCD conversion
// Shift-and-add-3 over one bit per cycle; the magnitude enters MSB first.
// ----------------------------------------------------------------------------
module i2d_bcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [i2d_pkg::VALUE_W-1:0]   mag,
  output i2d_pkg::conv_status_t         status,
  output logic [i2d_pkg::BCD_W-1:0]     bcd
);

  localparam int SW = i2d_pkg::STEP_W;

  logic [i2d_pkg::VALUE_W-1:0] shift_reg;
  logic [SW-1:0]               count;
  logic                        busy;
  logic                        done;
  logic [i2d_pkg::BCD_W-1:0]   adjusted;

  // Every digit that is five or more gets three added before the shift.
  always_comb begin
    for (int d = 0; d < i2d_pkg::DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adjusted[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        adjusted[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == SW'(i2d_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_reg <= mag;
      bcd       <= '0;
    end else if (busy) begin
      shift_reg <= {shift_reg[i2d_pkg::VALUE_W-2:0], 1'b0};
      bcd       <= {adjusted[i2d_pkg::BCD_W-2:0], shift_reg[i2d_pkg::VALUE_W-1]};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

[hw/rtl/int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Flow: an accepted number goes through the BCD unit, which shifts in one
//   magnitude bit per cycle, and then its text goes out.
// Throughput: a new number is taken only after the text of the last one,
//   n = 1..11 characters, is out; one character per cycle while the sink is ready.
// Reset: synchronous rst returns the sequencer to idle and drops text.valid.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
  input  logic           clk,
  input  logic           rst,
  i2d_in_if.sink         number,
  i2d_out_if.source      text
);

  localparam int IW = i2d_pkg::IDX_W;

  typedef enum logic [1:0] {IDLE, CONV, EMIT} state_t;

  state_t                       state;
  logic                         sign_pending;
  logic [IW-1:0]                idx;
  logic [IW-1:0]                top_digit;
  logic                         start;
  logic [i2d_pkg::VALUE_W-1:0]  raw;
  logic [i2d_pkg::VALUE_W-1:0]  mag;
  logic [i2d_pkg::BCD_W-1:0]    bcd;
  logic [3:0]                   digit;
  i2d_pkg::conv_status_t        status;

  // A new number is taken only when the previous text has gone out.
  assign number.ready = (state == IDLE);
  assign start        = number.valid && number.ready;

  // The magnitude is formed in unsigned arithmetic, so the most negative
  // value maps onto 2^31 without overflow.
  assign raw = number.value;
  assign mag = raw[i2d_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;

  i2d_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mag    (mag),
    .status (status),
    .bcd    (bcd)
  );

  // Highest nonzero digit; zero falls through to the single digit at index 0.
  always_comb begin
    top_digit = '0;
    for (int i = 0; i < i2d_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        top_digit = IW'(i);
      end
    end
  end

  assign digit = bcd[4*idx +: 4];

  // The minus sign goes out first, then the digits from the top index down.
  assign text.valid     = (state == EMIT);
  assign text.character = sign_pending ? i2d_pkg::CHAR_MINUS
                                       : (i2d_pkg::CHAR_ZERO + {4'd0, digit});
  assign text.last      = !sign_pending && (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      sign_pending <= 1'b0;
      idx          <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            sign_pending <= raw[i2d_pkg::VALUE_W-1];
            state        <= CONV;
          end
        end
        CONV: begin
          if (status.done) begin
            idx   <= top_digit;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (text.ready) begin
            if (sign_pending) begin
              sign_pending <= 1'b0;
            end else if (idx == '0) begin
              state <= IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The sequencer never takes a number while characters are still going out.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    text.valid |-> !number.ready)
    else $error("number accepted while text is pending");

  // The final character ends the run.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready && text.last |=> !text.valid)
    else $error("text continues after last character");

  // A minus sign is never the final character of a run.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    text.valid && (text.character == i2d_pkg::CHAR_MINUS) |-> !text.last)
    else $error("minus sign flagged as last");

  // Accepting a number starts the BCD unit and moves the sequencer to CONV.
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    number.valid && number.ready |=> status.busy && (state == CONV))
    else $error("conversion did not start");

endmodule
